// ===== sv/dcfmt_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal field formatter package
// Shared constants, controller state, command/status types and the
// shift-add-3 binary to BCD step.
// ----------------------------------------------------------------------------
package dcfmt_pkg;

	localparam int unsigned MAX_FIELD_WIDTH_DEF = 32;

	localparam int unsigned VALUE_W    = 64;
	localparam int unsigned FW_W       = 6;
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned POS_W      = 5;

	localparam int unsigned BCD_DIGITS    = 20;
	localparam int unsigned BCD_W         = 4 * BCD_DIGITS;
	localparam int unsigned BITS_PER_STEP = 2;
	localparam int unsigned CONV_STEPS    = VALUE_W / BITS_PER_STEP;
	localparam int unsigned CONV_CNT_W    = $clog2(CONV_STEPS);

	// ns -> ms with two decimals drops four decimal digits
	localparam int unsigned TIME_DROP = 4;

	localparam logic KIND_INT  = 1'b0;
	localparam logic KIND_TIME = 1'b1;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic convert;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic last_char;
	} dp_sts_t;

	function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd, input logic din);
		logic [BCD_W-1:0] adj;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
		end
		return {adj[BCD_W-2:0], din};
	endfunction

endpackage

// ===== sv/dcfmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Decimal field formatter controller
// Sequences load, BCD conversion and character emission.
// ----------------------------------------------------------------------------
module dcfmt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output dcfmt_pkg::dp_cmd_t  cmd,
	input  dcfmt_pkg::dp_sts_t  sts
);

	dcfmt_pkg::state_t state_q, state_nx;
	logic [dcfmt_pkg::CONV_CNT_W-1:0] cnt_q;
	logic conv_done;

	assign conv_done = (cnt_q == dcfmt_pkg::CONV_CNT_W'(dcfmt_pkg::CONV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dcfmt_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == dcfmt_pkg::ST_CONVERT) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			dcfmt_pkg::ST_IDLE: begin
				if (start) state_nx = dcfmt_pkg::ST_CONVERT;
			end
			dcfmt_pkg::ST_CONVERT: begin
				if (conv_done) state_nx = dcfmt_pkg::ST_EMIT;
			end
			dcfmt_pkg::ST_EMIT: begin
				if (sts.last_char) state_nx = dcfmt_pkg::ST_IDLE;
			end
			default: state_nx = dcfmt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			dcfmt_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			dcfmt_pkg::ST_CONVERT: begin
				cmd.convert = 1'b1;
			end
			dcfmt_pkg::ST_EMIT: begin
				cmd.emit = 1'b1;
			end
			default: busy = 1'b1;
		endcase
	end

endmodule

// ===== sv/dcfmt_dp.sv =====
// ----------------------------------------------------------------------------
// Decimal field formatter datapath
// Binary to BCD by shift-add-3, two bits a cycle; then one character a
// cycle picked from the BCD digits, right-aligned in the field.
// ----------------------------------------------------------------------------
module dcfmt_dp #(
	parameter int unsigned MAX_FIELD_WIDTH = dcfmt_pkg::MAX_FIELD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dcfmt_pkg::dp_cmd_t                cmd,
	output dcfmt_pkg::dp_sts_t                sts,
	input  logic                              kind,
	input  logic [dcfmt_pkg::VALUE_W-1:0]     value,
	input  logic [dcfmt_pkg::FW_W-1:0]        field_width,
	output logic                              strobe,
	output logic [dcfmt_pkg::CHAR_W-1:0]      character,
	output logic [dcfmt_pkg::POS_W-1:0]       position,
	output logic                              last
);

	localparam int unsigned WCW = $clog2(MAX_FIELD_WIDTH + 1);
	localparam int unsigned KW  = $clog2(MAX_FIELD_WIDTH);
	localparam int unsigned IW  = (KW + 1 > 5) ? KW + 1 : 5;
	localparam int unsigned PXW = (KW > dcfmt_pkg::POS_W) ? KW : dcfmt_pkg::POS_W;

	logic                             kind_q;
	logic [WCW-1:0]                   w_q;
	logic [KW-1:0]                    p_q;
	logic [dcfmt_pkg::BCD_W-1:0]      bcd_q;
	logic [dcfmt_pkg::VALUE_W-1:0]    shv_q;
	logic                             strobe_q;
	logic [dcfmt_pkg::CHAR_W-1:0]     char_q;
	logic [dcfmt_pkg::POS_W-1:0]      pos_q;
	logic                             last_q;

	logic [WCW-1:0]                   w_sat;
	logic [WCW-1:0]                   wm1;
	logic [KW-1:0]                    k;
	logic [IW-1:0]                    kx;
	logic [IW-1:0]                    idx;
	logic [4:0]                       di;
	logic                             in_rng;
	logic [3:0]                       digs [dcfmt_pkg::BCD_DIGITS];
	logic [dcfmt_pkg::BCD_DIGITS-1:0] nz;
	logic [dcfmt_pkg::BCD_DIGITS-1:0] above;
	logic [3:0]                       digit;
	logic                             abv;
	logic                             show;
	logic                             is_time;
	logic [dcfmt_pkg::CHAR_W-1:0]     ch;
	logic                             last_c;
	logic [PXW-1:0]                   p_ext;

	always_comb begin
		if (field_width == '0) begin
			w_sat = WCW'(1);
		end else if (int'(field_width) > int'(MAX_FIELD_WIDTH)) begin
			w_sat = WCW'(MAX_FIELD_WIDTH);
		end else begin
			w_sat = WCW'(field_width);
		end
	end

	always_comb begin
		for (int i = 0; i < dcfmt_pkg::BCD_DIGITS; i++) begin
			digs[i] = bcd_q[4*i +: 4];
			nz[i]   = |bcd_q[4*i +: 4];
		end
	end

	always_comb begin
		for (int i = 0; i < dcfmt_pkg::BCD_DIGITS; i++) begin
			above[i] = |(nz >> i);
		end
	end

	assign wm1     = w_q - WCW'(1);
	assign last_c  = (WCW'(p_q) == wm1);
	assign k       = KW'(wm1 - WCW'(p_q));
	assign kx      = IW'(k);
	assign is_time = (kind_q == dcfmt_pkg::KIND_TIME);

	always_comb begin
		if (!is_time) begin
			idx = kx;
		end else if (kx < IW'(2)) begin
			idx = kx + IW'(dcfmt_pkg::TIME_DROP);
		end else begin
			idx = kx + IW'(dcfmt_pkg::TIME_DROP - 1);
		end
	end

	assign in_rng = (idx < IW'(dcfmt_pkg::BCD_DIGITS));
	assign di     = idx[4:0];
	assign digit  = in_rng ? digs[di] : 4'd0;
	assign abv    = in_rng && above[di];
	assign show   = is_time ? ((kx <= IW'(3)) || abv) : ((kx == '0) || abv);

	always_comb begin
		if (is_time && (kx == IW'(2))) begin
			ch = dcfmt_pkg::CH_POINT;
		end else if (show) begin
			ch = dcfmt_pkg::CH_ZERO + {4'd0, digit};
		end else begin
			ch = dcfmt_pkg::CH_SPACE;
		end
	end

	assign p_ext         = PXW'(p_q);
	assign sts.last_char = last_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			w_q    <= w_sat;
			p_q    <= '0;
			bcd_q  <= '0;
			shv_q  <= value;
		end
		if (cmd.convert) begin
			bcd_q <= dcfmt_pkg::dabble(
				dcfmt_pkg::dabble(bcd_q, shv_q[dcfmt_pkg::VALUE_W-1]),
				shv_q[dcfmt_pkg::VALUE_W-2]);
			shv_q <= {shv_q[dcfmt_pkg::VALUE_W-3:0], 2'b00};
		end
		if (cmd.emit) begin
			char_q <= ch;
			pos_q  <= p_ext[dcfmt_pkg::POS_W-1:0];
			last_q <= last_c;
			p_q    <= p_q + 1'b1;
		end
	end

	assign strobe    = strobe_q;
	assign character = char_q;
	assign position  = pos_q;
	assign last      = last_q;

endmodule

// ===== sv/decimal_field_formatter.sv =====
// ----------------------------------------------------------------------------
// Decimal field formatter
// Formats a 64-bit value as a right-aligned ASCII field, integer or
// nanoseconds as milliseconds with two decimals, one character per beat.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  command   start / busy         kind, value, field_width
//  result    strobe (no stall)    character, position, last
//
//  An item is loaded, converted to BCD at two bits a cycle, then emitted
//  one character a cycle.
//  busy is high from acceptance until the last character is registered.
//  Results are one-cycle strobes; the receiver has no way to stall them.
//  Reset clears the controller and strobe; payload registers are not reset.
// ----------------------------------------------------------------------------
module decimal_field_formatter #(
	parameter int unsigned MAX_FIELD_WIDTH = dcfmt_pkg::MAX_FIELD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              kind,
	input  logic [dcfmt_pkg::VALUE_W-1:0]     value,
	input  logic [dcfmt_pkg::FW_W-1:0]        field_width,
	output logic                              strobe,
	output logic [dcfmt_pkg::CHAR_W-1:0]      character,
	output logic [dcfmt_pkg::POS_W-1:0]       position,
	output logic                              last
);

	dcfmt_pkg::dp_cmd_t cmd;
	dcfmt_pkg::dp_sts_t sts;

	dcfmt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	dcfmt_dp #(
		.MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.kind        (kind),
		.value       (value),
		.field_width (field_width),
		.strobe      (strobe),
		.character   (character),
		.position    (position),
		.last        (last)
	);

endmodule

// ===== sv/dcfmt_chk.sv =====
// ----------------------------------------------------------------------------
// Decimal field formatter checker
// Port-level sequencing checks, bound to the top level.
// ----------------------------------------------------------------------------
module dcfmt_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              strobe,
	input logic                              last,
	input logic [dcfmt_pkg::POS_W-1:0]       position
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	a_beats_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("gap inside a field");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("busy still high on final beat");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !strobe)
		else $error("beat without an active command");

	a_first_pos: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !$past(strobe) |-> position == '0)
		else $error("field did not start at leftmost position");

endmodule

bind decimal_field_formatter dcfmt_chk u_dcfmt_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.strobe   (strobe),
	.last     (last),
	.position (position)
);

// ===== verif/decimal_field_formatter_tb.sv =====
// ----------------------------------------------------------------------------
// Decimal field formatter testbench
// Drives integer and time commands through the start/busy port and checks
// every character beat against typed text or a behavioral formatter. The
// directed table opens; random commands with random sender gaps follow.
// ----------------------------------------------------------------------------
module decimal_field_formatter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_ITEMS = 480;
	localparam int unsigned QUIET_LIMIT  = 1000;
	localparam int unsigned DRAIN_CYCLES = 80;

	typedef struct packed {
		logic [dcfmt_pkg::CHAR_W-1:0] ch;
		logic [dcfmt_pkg::POS_W-1:0]  pos;
		logic                         last;
	} char_beat_t;

	typedef struct packed {
		logic                          k;
		logic [dcfmt_pkg::VALUE_W-1:0] v;
		logic [dcfmt_pkg::FW_W-1:0]    fw;
	} fmt_cmd_t;

	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          start       = 1'b0;
	logic                          kind        = dcfmt_pkg::KIND_INT;
	logic [dcfmt_pkg::VALUE_W-1:0] value       = '0;
	logic [dcfmt_pkg::FW_W-1:0]    field_width = 6'd1;
	logic                          busy;
	logic                          strobe;
	logic [dcfmt_pkg::CHAR_W-1:0]  character;
	logic [dcfmt_pkg::POS_W-1:0]   position;
	logic                          last;

	char_beat_t chars_due[$];
	fmt_cmd_t   table_cmds[$];
	string      table_texts[$];
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	bit          idle_on = 1'b1;

	decimal_field_formatter dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.value(value),
		.field_width(field_width),
		.strobe(strobe),
		.character(character),
		.position(position),
		.last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic int field_len(input logic [dcfmt_pkg::FW_W-1:0] fw);
		if (fw == 0)
			return 1;
		if (fw > dcfmt_pkg::MAX_FIELD_WIDTH_DEF)
			return dcfmt_pkg::MAX_FIELD_WIDTH_DEF;
		return int'(fw);
	endfunction

	function automatic logic [dcfmt_pkg::CHAR_W-1:0] digit_of(
			input logic [dcfmt_pkg::VALUE_W-1:0] v);
		return dcfmt_pkg::CH_ZERO + dcfmt_pkg::CHAR_W'(v % 10);
	endfunction

	function automatic void push_beat(input logic [dcfmt_pkg::CHAR_W-1:0] ch, input int p,
			input int n);
		char_beat_t b;
		b.ch = ch;
		b.pos = dcfmt_pkg::POS_W'(p);
		b.last = (p == n - 1);
		chars_due.push_back(b);
	endfunction

	// typed text is right-aligned, spaces fill the left
	function automatic void push_text(input string s, input int n);
		int idx;
		for (int p = 0; p < n; p++) begin
			idx = p - (n - s.len());
			push_beat((idx < 0) ? dcfmt_pkg::CH_SPACE : dcfmt_pkg::CHAR_W'(s[idx]), p, n);
		end
	endfunction

	function automatic void predict_field(input logic k,
			input logic [dcfmt_pkg::VALUE_W-1:0] val, input int n);
		logic [dcfmt_pkg::CHAR_W-1:0] txt [0:63];
		logic [dcfmt_pkg::VALUE_W-1:0] v;
		int w;
		int i;
		bit cut;
		for (int p = 0; p < 64; p++)
			txt[p] = dcfmt_pkg::CH_SPACE;
		w = n;
		v = val;
		cut = 1'b0;
		if (k == dcfmt_pkg::KIND_INT) begin
			do begin
				w--;
				txt[w] = digit_of(v);
				v = v / 10;
				cut = (w == 0) || (v == 0);
			end while (!cut);
		end else begin
			v = v / 10000;
			i = 0;
			do begin
				w--;
				txt[w] = digit_of(v);
				if (w == 0)
					cut = 1'b1;
				else begin
					v = v / 10;
					i++;
				end
			end while (!cut && i < 2 && v != 0);
			if (!cut) begin
				if (v != 0) begin
					w--;
					txt[w] = dcfmt_pkg::CH_POINT;
					while (w > 0 && !cut) begin
						w--;
						txt[w] = digit_of(v);
						v = v / 10;
						if (v == 0)
							cut = 1'b1;
					end
				end else begin
					if (i == 1) begin
						w--;
						txt[w] = dcfmt_pkg::CH_ZERO;
						if (w == 0)
							cut = 1'b1;
					end
					if (!cut) begin
						w--;
						txt[w] = dcfmt_pkg::CH_POINT;
						if (w > 0) begin
							w--;
							txt[w] = dcfmt_pkg::CH_ZERO;
						end
					end
				end
			end
		end
		for (int p = 0; p < n; p++)
			push_beat(txt[p], p, n);
	endfunction

	function automatic logic [dcfmt_pkg::VALUE_W-1:0] pow10(input int e);
		logic [dcfmt_pkg::VALUE_W-1:0] r;
		r = 64'd1;
		for (int j = 0; j < e; j++)
			r = r * 64'd10;
		return r;
	endfunction

	function automatic logic [dcfmt_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return {$urandom, $urandom};
			1: return dcfmt_pkg::VALUE_W'($urandom_range(0, 99999));
			2: return pow10($urandom_range(0, 19))
				+ dcfmt_pkg::VALUE_W'($urandom_range(0, 2)) - 64'd1;
			3: return pow10($urandom_range(0, 15)) * 64'd10000
				+ dcfmt_pkg::VALUE_W'($urandom_range(0, 2)) - 64'd1;
			4: return {$urandom, $urandom} >> $urandom_range(1, 63);
			default: return dcfmt_pkg::VALUE_W'($urandom_range(0, 2000000));
		endcase
	endfunction

	function automatic logic [dcfmt_pkg::FW_W-1:0] pick_width();
		case ($urandom_range(0, 9))
			0: return ($urandom_range(0, 1) != 0) ? dcfmt_pkg::FW_W'(0)
				: dcfmt_pkg::FW_W'($urandom_range(33, 63));
			1: return dcfmt_pkg::FW_W'($urandom_range(1, 4));
			default: return dcfmt_pkg::FW_W'($urandom_range(1, 32));
		endcase
	endfunction

	function automatic void add_row(input logic k, input logic [dcfmt_pkg::VALUE_W-1:0] v,
			input logic [dcfmt_pkg::FW_W-1:0] fw, input string s);
		fmt_cmd_t c;
		c.k = k;
		c.v = v;
		c.fw = fw;
		table_cmds.push_back(c);
		table_texts.push_back(s);
	endfunction

	// an empty text means the predictor supplies the field
	task automatic send_command(input logic k, input logic [dcfmt_pkg::VALUE_W-1:0] v,
			input logic [dcfmt_pkg::FW_W-1:0] fw, input string s);
		int n;
		start <= 1'b1;
		kind <= k;
		value <= v;
		field_width <= fw;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		n = field_len(fw);
		if (s.len() == 0)
			predict_field(k, v, n);
		else
			push_text(s, n);
	endtask

	task automatic sender_gap();
		int gap;
		bit after_done;
		gap = idle_on ? $urandom_range(0, 15) : 0;
		after_done = idle_on && ($urandom_range(0, 1) != 0);
		if (gap != 0 || after_done) begin
			start <= 1'b0;
			if (after_done) begin
				do
					@(posedge clk);
				while (busy !== 1'b0);
			end
			repeat (gap) @(posedge clk);
		end
	endtask

	// one character beat per strobe, no back-pressure
	always @(posedge clk) begin
		char_beat_t want;
		if (arst_n && strobe === 1'b1) begin
			if (chars_due.size() == 0)
				report_mismatch($sformatf("unexpected character 0x%02h at position %0d",
					character, position));
			else begin
				want = chars_due.pop_front();
				if (character !== want.ch)
					report_mismatch($sformatf("position %0d: character 0x%02h, want 0x%02h",
						want.pos, character, want.ch));
				if (position !== want.pos)
					report_mismatch($sformatf("position %0d, want %0d", position, want.pos));
				if (last !== want.last)
					report_mismatch($sformatf("position %0d: last %b, want %b",
						want.pos, last, want.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && busy === 1'b0 && arst_n) || strobe === 1'b1)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		add_row(dcfmt_pkg::KIND_INT,  64'd0, 6'd1, "0");
		add_row(dcfmt_pkg::KIND_INT,  64'd0, 6'd0, "0");
		add_row(dcfmt_pkg::KIND_INT,  64'hFFFF_FFFF_FFFF_FFFF, 6'd32, "18446744073709551615");
		add_row(dcfmt_pkg::KIND_INT,  64'hFFFF_FFFF_FFFF_FFFF, 6'd63, "18446744073709551615");
		add_row(dcfmt_pkg::KIND_INT,  64'd12345, 6'd3, "345");
		add_row(dcfmt_pkg::KIND_INT,  64'd12345, 6'd8, "12345");
		add_row(dcfmt_pkg::KIND_INT,  64'd1000000, 6'd7, "1000000");
		add_row(dcfmt_pkg::KIND_TIME, 64'd0, 6'd6, "0.00");
		add_row(dcfmt_pkg::KIND_TIME, 64'd9999, 6'd4, "0.00");
		add_row(dcfmt_pkg::KIND_TIME, 64'd9999, 6'd3, ".00");
		add_row(dcfmt_pkg::KIND_TIME, 64'd9999, 6'd2, "00");
		add_row(dcfmt_pkg::KIND_TIME, 64'd9999, 6'd1, "0");
		add_row(dcfmt_pkg::KIND_TIME, 64'd10000, 6'd5, "0.01");
		add_row(dcfmt_pkg::KIND_TIME, 64'd120000, 6'd4, "0.12");
		add_row(dcfmt_pkg::KIND_TIME, 64'd105000, 6'd5, "0.10");
		add_row(dcfmt_pkg::KIND_TIME, 64'd1230000, 6'd4, "1.23");
		add_row(dcfmt_pkg::KIND_TIME, 64'd1234567890, 6'd10, "1234.56");
		add_row(dcfmt_pkg::KIND_TIME, 64'd1234567890, 6'd3, ".56");
		add_row(dcfmt_pkg::KIND_TIME, 64'd1234567890, 6'd2, "56");
		add_row(dcfmt_pkg::KIND_TIME, 64'd99990000, 6'd63, "99.99");
		add_row(dcfmt_pkg::KIND_TIME, 64'hFFFF_FFFF_FFFF_FFFF, 6'd32, "18446744073709.55");
		add_row(dcfmt_pkg::KIND_INT,  64'd9876543210, 6'd32, "");
		add_row(dcfmt_pkg::KIND_TIME, 64'h8000_0000_0000_0000, 6'd20, "");
		add_row(dcfmt_pkg::KIND_INT,  64'd5, 6'd33, "");
		add_row(dcfmt_pkg::KIND_TIME, 64'd1234567890, 6'd0, "");

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < table_cmds.size(); r++) begin
			send_command(table_cmds[r].k, table_cmds[r].v, table_cmds[r].fw, table_texts[r]);
			sender_gap();
		end

		for (int r = 0; r < RANDOM_ITEMS; r++) begin
			if (r % 40 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			send_command(logic'($urandom_range(0, 1)), pick_value(), pick_width(), "");
			sender_gap();
		end
		start <= 1'b0;

		while (chars_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
